// File: rtl/opp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OFDM packet parameter package
// Constants, rate lookups and shared types for the packet parameter block.
// ----------------------------------------------------------------------------
package opp_pkg;

  localparam int unsigned TAIL_BITS    = 6;
  localparam int unsigned SERVICE_BITS = 16;
  localparam int unsigned MAX_OCTETS   = 4095;
  localparam int unsigned SUBCARRIERS  = 48;

  localparam int unsigned RATE_W   = 3;
  localparam int unsigned OCTETS_W = 12;
  // numerator of the symbol division: 8 * octets + tail + service
  localparam int unsigned NUM_W    = 16;
  localparam int unsigned DBPS_W   = 8;
  localparam int unsigned SYMS_W   = 11;

  typedef logic [RATE_W-1:0]   rate_idx_t;
  typedef logic [OCTETS_W-1:0] octets_t;

  // word travelling down the divider chain
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DBPS_W-1:0] rem;
    logic [NUM_W-1:0]  quo;
    logic [DBPS_W-1:0] dbps;
    rate_idx_t         rate_index;
  } opp_div_t;

  typedef struct packed {
    logic [2:0]        bits_per_carrier;
    logic [6:0]        rate_times_120;
    logic [DBPS_W-1:0] data_bits_per_symbol;
    logic [4:0]        data_bytes_per_symbol;
    logic [2:0]        data_words_per_symbol;
    logic [15:0]       uncoded_bits;
    logic [7:0]        pad_bits;
    logic [16:0]       coded_bits;
    logic [16:0]       const_points;
    logic [1:0]        modulation_index;
    logic [SYMS_W-1:0] data_symbols;
    logic              special_case;
  } opp_res_t;

  function automatic logic [2:0] bpc_lut(rate_idx_t ri);
    logic [2:0] v;
    case (ri)
      3'd0, 3'd1: v = 3'd1;
      3'd2, 3'd3: v = 3'd2;
      3'd4, 3'd5: v = 3'd4;
      default:    v = 3'd6;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] rate_lut(rate_idx_t ri);
    logic [6:0] v;
    case (ri)
      3'd0, 3'd2, 3'd4: v = 7'd60;
      3'd6:             v = 7'd80;
      default:          v = 7'd90;
    endcase
    return v;
  endfunction

  // 48 * bpc * rate / 120, all exact
  function automatic logic [DBPS_W-1:0] dbps_lut(rate_idx_t ri);
    logic [DBPS_W-1:0] v;
    case (ri)
      3'd0:    v = 8'd24;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd48;
      3'd3:    v = 8'd72;
      3'd4:    v = 8'd96;
      3'd5:    v = 8'd144;
      3'd6:    v = 8'd192;
      default: v = 8'd216;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/opp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Rate index and payload length, valid/ready handshake.
// ----------------------------------------------------------------------------
interface opp_in_if;
  import opp_pkg::*;

  logic      valid;
  logic      ready;
  rate_idx_t rate_index;
  octets_t   info_octets;

  modport source (output valid, rate_index, info_octets, input ready);
  modport sink   (input valid, rate_index, info_octets, output ready);
endinterface

// File: rtl/opp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Derived packet parameters, valid/ready handshake.
// ----------------------------------------------------------------------------
interface opp_out_if;
  import opp_pkg::*;

  logic              valid;
  logic              ready;
  logic [2:0]        bits_per_carrier;
  logic [6:0]        rate_times_120;
  logic [DBPS_W-1:0] data_bits_per_symbol;
  logic [4:0]        data_bytes_per_symbol;
  logic [2:0]        data_words_per_symbol;
  logic [15:0]       uncoded_bits;
  logic [7:0]        pad_bits;
  logic [16:0]       coded_bits;
  logic [16:0]       const_points;
  logic [1:0]        modulation_index;
  logic [SYMS_W-1:0] data_symbols;
  logic              special_case;

  modport source (output valid, bits_per_carrier, rate_times_120, data_bits_per_symbol,
                  data_bytes_per_symbol, data_words_per_symbol, uncoded_bits, pad_bits,
                  coded_bits, const_points, modulation_index, data_symbols,
                  special_case, input ready);
  modport sink   (input valid, bits_per_carrier, rate_times_120, data_bits_per_symbol,
                  data_bytes_per_symbol, data_words_per_symbol, uncoded_bits, pad_bits,
                  coded_bits, const_points, modulation_index, data_symbols,
                  special_case, output ready);
endinterface

// File: rtl/opp_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in a numerator bit, retires one
// quotient bit and hands the word to the next cell.
// ----------------------------------------------------------------------------
module opp_div_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  opp_pkg::opp_div_t data_i,
  output logic             valid_o,
  output opp_pkg::opp_div_t data_o
);
  import opp_pkg::*;

  logic              valid_q;
  opp_div_t          data_q, data_d;
  logic [DBPS_W:0]   trial;
  logic [DBPS_W:0]   diff;
  logic              fits;

  // remainder stays below the divisor, so it fits in DBPS_W bits either way
  always_comb begin
    trial  = {data_i.rem, data_i.num[NUM_W-1]};
    diff   = trial - {1'b0, data_i.dbps};
    fits   = trial >= {1'b0, data_i.dbps};
    data_d = data_i;
    data_d.num = {data_i.num[NUM_W-2:0], 1'b0};
    data_d.rem = fits ? diff[DBPS_W-1:0] : trial[DBPS_W-1:0];
    data_d.quo = {data_i.quo[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/opp_finish.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result builder
// Turns quotient and remainder of the symbol division into the full set of
// packet parameters.
// ----------------------------------------------------------------------------
module opp_finish (
  input  opp_pkg::opp_div_t div_i,
  output opp_pkg::opp_res_t res_o
);
  import opp_pkg::*;

  logic [2:0]        bpc;
  logic [4:0]        bytes;
  logic              rem_nz;
  logic [SYMS_W-1:0] syms;
  logic [8:0]        cbps;
  logic [18:0]       unc_full;
  logic [19:0]       coded_full;
  logic [16:0]       pts_full;
  logic [DBPS_W-1:0] gap;
  logic [DBPS_W-1:0] pad;

  always_comb begin
    bpc        = bpc_lut(div_i.rate_index);
    bytes      = div_i.dbps[DBPS_W-1:3];
    rem_nz     = |div_i.rem;
    syms       = div_i.quo[SYMS_W-1:0] + SYMS_W'(rem_nz);
    cbps       = 9'(SUBCARRIERS) * 9'(bpc);
    unc_full   = 19'(syms) * 19'(div_i.dbps);
    coded_full = 20'(syms) * 20'(cbps);
    pts_full   = 17'(syms) * 17'(SUBCARRIERS);
    // rounding up to whole symbols adds dbps - rem on top of the numerator
    gap        = rem_nz ? (div_i.dbps - div_i.rem) : '0;
    pad        = gap + DBPS_W'(SERVICE_BITS);

    res_o.bits_per_carrier      = bpc;
    res_o.rate_times_120        = rate_lut(div_i.rate_index);
    res_o.data_bits_per_symbol  = div_i.dbps;
    res_o.data_bytes_per_symbol = bytes;
    res_o.data_words_per_symbol = bytes[4:2] + 3'(|bytes[1:0]);
    res_o.uncoded_bits          = unc_full[15:0];
    res_o.pad_bits              = pad;
    res_o.coded_bits            = coded_full[16:0];
    res_o.const_points          = pts_full;
    res_o.modulation_index      = bpc[2:1];
    res_o.data_symbols          = syms;
    // without the tail the count drops by one exactly when the tail alone
    // spills into the last symbol
    res_o.special_case          = rem_nz && (32'(div_i.rem) <= TAIL_BITS);
  end

endmodule

// File: rtl/ofdm_packet_parameter_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OFDM packet parameter calculator
// Rate lookup, pipelined symbol-count divider and result formatting.
// ----------------------------------------------------------------------------
// Takes one request word per clock while the result side is not stalled and
// returns one result word per request, in order. The pipeline is the divider
// chain: one entry stage for the rate lookup, sixteen cells that each retire
// one quotient bit of the symbol count, and the output register. A stall on
// the result side freezes the whole chain, so requests are held rather than
// dropped.
module ofdm_packet_parameter_calc (
  input  logic      clk_i,
  input  logic      rst_ni,
  opp_in_if.sink    in_i,
  opp_out_if.source out_o
);
  import opp_pkg::*;

  logic              en;
  logic              s0_vld_q;
  opp_div_t          s0_q, s0_d;
  octets_t           oct_sat;
  logic [NUM_W:0]    vld;
  opp_div_t          chain [NUM_W+1];
  opp_res_t          res_d, res_q;
  logic              out_vld_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    oct_sat = (32'(in_i.info_octets) > MAX_OCTETS) ? OCTETS_W'(MAX_OCTETS)
                                                   : in_i.info_octets;
    s0_d.num        = NUM_W'({oct_sat, 3'b000}) + NUM_W'(TAIL_BITS + SERVICE_BITS);
    s0_d.rem        = '0;
    s0_d.quo        = '0;
    s0_d.dbps       = dbps_lut(in_i.rate_index);
    s0_d.rate_index = in_i.rate_index;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q  <= in_i.valid;
      out_vld_q <= vld[NUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q  <= s0_d;
      res_q <= res_d;
    end
  end

  assign vld[0]   = s0_vld_q;
  assign chain[0] = s0_q;

  for (genvar g = 0; g < NUM_W; g++) begin : g_cell
    opp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[g]),
      .data_i  (chain[g]),
      .valid_o (vld[g+1]),
      .data_o  (chain[g+1])
    );
  end

  opp_finish u_finish (
    .div_i (chain[NUM_W]),
    .res_o (res_d)
  );

  assign out_o.valid                 = out_vld_q;
  assign out_o.bits_per_carrier      = res_q.bits_per_carrier;
  assign out_o.rate_times_120        = res_q.rate_times_120;
  assign out_o.data_bits_per_symbol  = res_q.data_bits_per_symbol;
  assign out_o.data_bytes_per_symbol = res_q.data_bytes_per_symbol;
  assign out_o.data_words_per_symbol = res_q.data_words_per_symbol;
  assign out_o.uncoded_bits          = res_q.uncoded_bits;
  assign out_o.pad_bits              = res_q.pad_bits;
  assign out_o.coded_bits            = res_q.coded_bits;
  assign out_o.const_points          = res_q.const_points;
  assign out_o.modulation_index      = res_q.modulation_index;
  assign out_o.data_symbols          = res_q.data_symbols;
  assign out_o.special_case          = res_q.special_case;

  // a stalled chain must not move or lose a word
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld) && $stable(out_vld_q))
    else $error("divider chain moved while stalled");

  a_pad_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (32'(res_q.pad_bits) >= SERVICE_BITS))
    else $error("pad bits below service field length");

  a_mod_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.modulation_index == res_q.bits_per_carrier[2:1]))
    else $error("modulation index inconsistent with bits per carrier");

  a_special_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.special_case) |->
      (32'(res_q.pad_bits) + TAIL_BITS >= 32'(res_q.data_bits_per_symbol) + SERVICE_BITS))
    else $error("special case flagged without tail spill");

endmodule

// File: test/ofdm_packet_parameter_calc_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OFDM packet parameter calculator testbench
// Feeds rate/length requests through the valid/ready channel with random
// gaps on both sides, derives every result field from the 802.11a rate
// table in the bench itself and checks each returned word in order.
// ----------------------------------------------------------------------------
module ofdm_packet_parameter_calc_tb;
  import opp_pkg::*;

  localparam rate_idx_t RATE_6M  = 3'd0;
  localparam rate_idx_t RATE_9M  = 3'd1;
  localparam rate_idx_t RATE_12M = 3'd2;
  localparam rate_idx_t RATE_18M = 3'd3;
  localparam rate_idx_t RATE_24M = 3'd4;
  localparam rate_idx_t RATE_36M = 3'd5;
  localparam rate_idx_t RATE_48M = 3'd6;
  localparam rate_idx_t RATE_54M = 3'd7;

  localparam int unsigned RANDOM_REQS = 1625;
  localparam int unsigned IDLE_PCT    = 11;

  typedef struct {
    rate_idx_t rate;
    octets_t   octets;
    bit        drain;   // hold off until every result is back
  } packet_req_t;

  logic clk_i;
  logic rst_ni;

  opp_in_if  req_if ();
  opp_out_if res_if ();

  ofdm_packet_parameter_calc uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  packet_req_t req_queue[$];
  opp_res_t    params_exp[$];
  int unsigned sent_cnt;
  int unsigned recv_cnt;
  int unsigned mismatch_cnt;
  bit          drv_go;

  function automatic opp_res_t calc_packet_params(rate_idx_t rate, octets_t octets);
    opp_res_t    res;
    int unsigned bpc, r120, dbps, bytes, info, n_oct, syms, uncoded, coded, sd_syms;
    case (rate)
      RATE_6M:  begin bpc = 1; r120 = 60; end
      RATE_9M:  begin bpc = 1; r120 = 90; end
      RATE_12M: begin bpc = 2; r120 = 60; end
      RATE_18M: begin bpc = 2; r120 = 90; end
      RATE_24M: begin bpc = 4; r120 = 60; end
      RATE_36M: begin bpc = 4; r120 = 90; end
      RATE_48M: begin bpc = 6; r120 = 80; end
      default:  begin bpc = 6; r120 = 90; end
    endcase
    n_oct = (32'(octets) > MAX_OCTETS) ? MAX_OCTETS : 32'(octets);
    dbps  = SUBCARRIERS * bpc * r120 / 120;
    bytes = dbps >> 3;
    info  = n_oct * 8;
    syms  = (info + TAIL_BITS + SERVICE_BITS + dbps - 1) / dbps;
    uncoded = syms * dbps;
    coded   = uncoded * 120 / r120;
    // symbol count without the tail; differs when the tail needs a symbol of its own
    sd_syms = (info + SERVICE_BITS + dbps - 1) / dbps;
    res.bits_per_carrier      = 3'(bpc);
    res.rate_times_120        = 7'(r120);
    res.data_bits_per_symbol  = 8'(dbps);
    res.data_bytes_per_symbol = 5'(bytes);
    res.data_words_per_symbol = 3'((bytes + 3) / 4);
    res.uncoded_bits          = 16'(uncoded);
    res.pad_bits              = 8'(uncoded - info - TAIL_BITS);
    res.coded_bits            = 17'(coded);
    res.const_points          = 17'(coded / bpc);
    res.modulation_index      = 2'(bpc >> 1);
    res.data_symbols          = 11'(syms);
    res.special_case          = (sd_syms != syms);
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.rate_index  <= RATE_6M;
      req_if.info_octets <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        params_exp.push_back(calc_packet_params(req_if.rate_index, req_if.info_octets));
        void'(req_queue.pop_front());
        sent_cnt++;
      end
      if (!(req_if.valid && !req_if.ready)) begin
        drv_go = (req_queue.size() != 0);
        if (drv_go && req_queue[0].drain && params_exp.size() != 0)
          drv_go = 1'b0;
        // idle-free stretch in the middle of the run
        if (drv_go && !(sent_cnt >= 500 && sent_cnt < 800) &&
            $urandom_range(99) < IDLE_PCT)
          drv_go = 1'b0;
        req_if.valid <= drv_go;
        if (drv_go) begin
          req_if.rate_index  <= req_queue[0].rate;
          req_if.info_octets <= req_queue[0].octets;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        recv_cnt++;
        if (params_exp.size() == 0) begin
          $display("%0t ns: unexpected result word, expected none, actual data_symbols %0d",
                   $time, res_if.data_symbols);
          mismatch_cnt++;
        end else begin
          opp_res_t exp_w;
          exp_w = params_exp.pop_front();
          check_field("bits_per_carrier", 32'(exp_w.bits_per_carrier),
                      32'(res_if.bits_per_carrier));
          check_field("rate_times_120", 32'(exp_w.rate_times_120),
                      32'(res_if.rate_times_120));
          check_field("data_bits_per_symbol", 32'(exp_w.data_bits_per_symbol),
                      32'(res_if.data_bits_per_symbol));
          check_field("data_bytes_per_symbol", 32'(exp_w.data_bytes_per_symbol),
                      32'(res_if.data_bytes_per_symbol));
          check_field("data_words_per_symbol", 32'(exp_w.data_words_per_symbol),
                      32'(res_if.data_words_per_symbol));
          check_field("uncoded_bits", 32'(exp_w.uncoded_bits), 32'(res_if.uncoded_bits));
          check_field("pad_bits", 32'(exp_w.pad_bits), 32'(res_if.pad_bits));
          check_field("coded_bits", 32'(exp_w.coded_bits), 32'(res_if.coded_bits));
          check_field("const_points", 32'(exp_w.const_points), 32'(res_if.const_points));
          check_field("modulation_index", 32'(exp_w.modulation_index),
                      32'(res_if.modulation_index));
          check_field("data_symbols", 32'(exp_w.data_symbols), 32'(res_if.data_symbols));
          check_field("special_case", 32'(exp_w.special_case), 32'(res_if.special_case));
        end
      end
      res_if.ready <= (recv_cnt >= 500 && recv_cnt < 800) || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    packet_req_t req;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.rate_index  = RATE_6M;
    req_if.info_octets = '0;
    res_if.ready       = 1'b0;
    sent_cnt     = 0;
    recv_cnt     = 0;
    mismatch_cnt = 0;

    // directed: empty, single octet and longest payload at every rate
    for (int r = 0; r < 8; r++) begin
      req.rate   = rate_idx_t'(r);
      req.drain  = 1'b0;
      req.octets = '0;
      req_queue.push_back(req);
      req.octets = 12'd1;           // 6 Mbps: tail spills into a second symbol
      req_queue.push_back(req);
      req.octets = 12'(MAX_OCTETS);
      req_queue.push_back(req);
    end
    // service plus data fills exactly one 54 Mbps symbol, tail spills over
    req.rate   = RATE_54M;
    req.octets = 12'd25;
    req_queue.push_back(req);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      req.rate  = rate_idx_t'($urandom_range(7));
      req.drain = (i == 0) || (i == 1000);
      case ($urandom_range(3))
        0:       req.octets = 12'($urandom_range(63));
        1:       req.octets = 12'($urandom_range(4095, 4032));
        default: req.octets = 12'($urandom_range(4095));
      endcase
      req_queue.push_back(req);
    end

    repeat (7) @(posedge clk_i);
    rst_ni = 1'b1;

    while (req_queue.size() != 0 || params_exp.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0 && params_exp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
